### rtl/psr_pkg.sv
// psr_pkg: shared constants, control/status structs and the packed slot function
// for the packed symmetric matrix to sparse rows unit. no dependencies.

package psr_pkg;

  localparam int SIDE_MAX    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int STORE_DEPTH = SIDE_MAX * (SIDE_MAX + 1) / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int ROW_W       = 5;
  localparam int CNT_W       = 9;
  localparam int SIDE_MIN    = 2;
  localparam int COUNT_MAX   = 256;

  // stream words padded up to whole bytes
  localparam int IN_DATA_W  = ((2 * ROW_W + VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * ROW_W + VALUE_WIDTH + 3 * CNT_W + 7) / 8) * 8;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  typedef struct packed {
    logic write_elem;
    logic capture_emit;
    logic scan_step;
    logic emit_record;
  } psr_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } psr_stat_t;

  // packed lower-triangular slot of (hi,lo), 1-based, hi >= lo
  function automatic logic [ADDR_W-1:0] slot_of(input logic [ROW_W-1:0] hi,
                                                input logic [ROW_W-1:0] lo);
    logic [2*ROW_W-1:0] prod;
    logic [2*ROW_W-1:0] sum;
    prod = {{ROW_W{1'b0}}, hi} * ({{ROW_W{1'b0}}, hi} - {{(2*ROW_W-1){1'b0}}, 1'b1});
    sum  = (prod >> 1) + {{ROW_W{1'b0}}, lo} - {{(2*ROW_W-1){1'b0}}, 1'b1};
    return sum[ADDR_W-1:0];
  endfunction

endpackage

### rtl/packed_symmetric_to_sparse_rows_unit.sv
// packed_symmetric_to_sparse_rows_unit: a load item gives no result.
// an emit-row item has an accept cycle, then one column read per cycle, unless the output stalls,
// from the element store's single read port with registered read, a step to see the scan end
// and the row record; a row outside the side skips the column reads; output stalls
// hold the scan and the record. one item at a time.
// reset (rst, synchronous, active high) sets side to 2 and the triple count to 0;
// the element store is not cleared and reads undefined until written.

module packed_symmetric_to_sparse_rows_unit (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [1:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [psr_pkg::IN_DATA_W-1:0]      s_tdata,   // row, col, value, zero pad
  input  logic [0:0]                         s_tuser,   // command
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [psr_pkg::OUT_DATA_W-1:0]     m_tdata,   // triple_row, triple_col,
                                                        // triple_value, triple_index,
                                                        // row_start, total_count, pad
  output logic [0:0]                         m_tuser,   // is_row_record
  output logic                               m_tlast
);

  localparam int RW = psr_pkg::ROW_W;
  localparam int VW = psr_pkg::VALUE_WIDTH;
  localparam int CW = psr_pkg::CNT_W;
  localparam int OUT_USED = 2 * RW + VW + 3 * CW;

  psr_pkg::psr_cmd_t  cmd;
  psr_pkg::psr_stat_t stat;

  logic [RW-1:0] side;
  logic          out_is_record;
  logic [RW-1:0] out_row, out_col;
  logic [VW-1:0] out_value;
  logic [CW-1:0] out_index, out_start, out_total;

  // single register, every address decodes to it
  assign pready = 1'b1;
  assign prdata = {{(32 - RW){1'b0}}, side};

  psr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_command (s_tuser[0]),
    .in_ready   (s_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  psr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (psel && penable && pwrite && pready && (paddr == 2'd0 || paddr != 2'd0)),
    .cfg_wdata     (pwdata[RW-1:0]),
    .side          (side),
    .in_row        (s_tdata[RW-1:0]),
    .in_col        (s_tdata[2*RW-1:RW]),
    .in_value      (s_tdata[2*RW+VW-1:2*RW]),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_is_record (out_is_record),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_index     (out_index),
    .out_start     (out_start),
    .out_total     (out_total)
  );

  assign m_tdata = {{(psr_pkg::OUT_DATA_W - OUT_USED){1'b0}},
                    out_total, out_start, out_index, out_value, out_col, out_row};
  assign m_tuser = out_is_record;
  assign m_tlast = out_is_record;

endmodule

### rtl/psr_ram.sv
// psr_ram: generic single write port, single read port ram with registered read.
// no dependencies.

module psr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 136
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/psr_ctrl.sv
// psr_ctrl: item sequencer for load and emit-row commands.
// depends on psr_pkg.

module psr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_command,
  output logic               in_ready,
  input  psr_pkg::psr_stat_t stat,
  output psr_pkg::psr_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_RECORD = 3'b100
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    cmd              = '0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_command == psr_pkg::CMD_LOAD) begin
            cmd.write_elem = 1'b1;
          end else begin
            cmd.capture_emit = 1'b1;
            state_next       = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_RECORD;
        end
      end
      ST_RECORD: begin
        if (stat.out_free) begin
          cmd.emit_record = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/psr_dp.sv
// psr_dp: element store, column scan, triple counter and output register.
// depends on psr_pkg and psr_ram.

module psr_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [psr_pkg::ROW_W-1:0]             cfg_wdata,
  output logic [psr_pkg::ROW_W-1:0]             side,
  input  logic [psr_pkg::ROW_W-1:0]             in_row,
  input  logic [psr_pkg::ROW_W-1:0]             in_col,
  input  logic [psr_pkg::VALUE_WIDTH-1:0]       in_value,
  input  psr_pkg::psr_cmd_t                     cmd,
  output psr_pkg::psr_stat_t                    stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_is_record,
  output logic [psr_pkg::ROW_W-1:0]             out_row,
  output logic [psr_pkg::ROW_W-1:0]             out_col,
  output logic [psr_pkg::VALUE_WIDTH-1:0]       out_value,
  output logic [psr_pkg::CNT_W-1:0]             out_index,
  output logic [psr_pkg::CNT_W-1:0]             out_start,
  output logic [psr_pkg::CNT_W-1:0]             out_total
);

  localparam logic [psr_pkg::ROW_W-1:0] ONE_R = psr_pkg::ROW_W'(1);
  localparam logic [psr_pkg::ROW_W-1:0] SMIN  = psr_pkg::ROW_W'(psr_pkg::SIDE_MIN);
  localparam logic [psr_pkg::ROW_W-1:0] SMAX  = psr_pkg::ROW_W'(psr_pkg::SIDE_MAX);
  localparam logic [psr_pkg::CNT_W-1:0] CMAX  = psr_pkg::CNT_W'(psr_pkg::COUNT_MAX);

  logic [psr_pkg::ROW_W-1:0]       n;
  logic                            ld_ok;
  logic [psr_pkg::ROW_W-1:0]       ld_hi, ld_lo;
  logic [psr_pkg::ADDR_W-1:0]      waddr, raddr;
  logic [psr_pkg::ROW_W-1:0]       rd_hi, rd_lo;
  logic [psr_pkg::VALUE_WIDTH-1:0] rdata;

  logic [psr_pkg::ROW_W-1:0]       row_q;
  logic                            row_ok;
  logic [psr_pkg::ROW_W-1:0]       col_rd;
  logic [psr_pkg::ROW_W-1:0]       col_data;
  logic                            data_valid;
  logic [psr_pkg::CNT_W-1:0]       count;
  logic [psr_pkg::CNT_W-1:0]       count_next;
  logic [psr_pkg::CNT_W-1:0]       start;

  logic nonzero, out_free, step, issue, emit_triple, cols_left;

  // side clamped into the supported range
  always_comb begin
    if (side < SMIN) begin
      n = SMIN;
    end else if (side > SMAX) begin
      n = SMAX;
    end else begin
      n = side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side <= SMIN;
    end else if (cfg_we) begin
      side <= cfg_wdata;
    end
  end

  // load path: swap to lower triangle
  assign ld_ok = (in_row != '0) && (in_row <= n) && (in_col != '0) && (in_col <= n);
  assign ld_hi = (in_col > in_row) ? in_col : in_row;
  assign ld_lo = (in_col > in_row) ? in_row : in_col;
  assign waddr = psr_pkg::slot_of(ld_hi, ld_lo);

  // scan path: mirrored entry above the diagonal
  assign rd_hi = (col_rd > row_q) ? col_rd : row_q;
  assign rd_lo = (col_rd > row_q) ? row_q : col_rd;
  assign raddr = psr_pkg::slot_of(rd_hi, rd_lo);

  assign nonzero     = (rdata != '0);
  assign out_free    = !out_valid || out_ready;
  assign cols_left   = row_ok && (col_rd <= n);
  assign step        = cmd.scan_step && (!data_valid || !nonzero || out_free);
  assign issue       = step && cols_left;
  assign emit_triple = step && data_valid && nonzero;
  assign count_next  = (count < CMAX) ? count + 1'b1 : count;

  assign stat.scan_done = !data_valid && !cols_left;
  assign stat.out_free  = out_free;

  psr_ram #(
    .WIDTH (psr_pkg::VALUE_WIDTH),
    .DEPTH (psr_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.write_elem && ld_ok),
    .waddr (waddr),
    .wdata (in_value),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      data_valid <= 1'b0;
      count      <= '0;
    end else if (cmd.capture_emit) begin
      data_valid <= 1'b0;
      if (in_row == ONE_R) begin
        count <= '0;
      end
    end else begin
      if (step) begin
        data_valid <= issue;
      end
      if (emit_triple) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture_emit) begin
      row_q  <= in_row;
      row_ok <= (in_row != '0) && (in_row <= n);
      col_rd <= ONE_R;
      start  <= '0;
    end else begin
      if (issue) begin
        col_rd   <= col_rd + 1'b1;
        col_data <= col_rd;
      end
      if (emit_triple && start == '0) begin
        start <= count_next;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_triple || cmd.emit_record) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_triple) begin
      out_is_record <= 1'b0;
      out_row       <= row_q;
      out_col       <= col_data;
      out_value     <= rdata;
      out_index     <= count_next;
      out_start     <= '0;
      out_total     <= '0;
    end else if (cmd.emit_record) begin
      out_is_record <= 1'b1;
      out_row       <= '0;
      out_col       <= '0;
      out_value     <= '0;
      out_index     <= '0;
      out_start     <= start;
      out_total     <= count;
    end
  end

endmodule
